// ----- design/fqr_pkg.sv -----
// Package for the ready queue with removal from any position.
// Holds operation codes, port field widths and the control bundle that
// the top level hands to every queue cell.
package fqr_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 32;
	localparam int unsigned ID_BITS_DEF     = 8;

	// Widths of the stream fields
	localparam int unsigned FUNC_W     = 2;
	localparam int unsigned PORT_ID_W  = 8;
	localparam int unsigned COUNT_W    = 6;
	localparam int unsigned WIDE_ID_W  = 16;
	localparam int unsigned IN_DATA_W  = 16;
	localparam int unsigned OUT_DATA_W = 24;

	// Operation codes
	localparam logic [FUNC_W-1:0] OP_APPEND = 2'd0;
	localparam logic [FUNC_W-1:0] OP_TAKE   = 2'd1;
	localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd2;

	// Per-item command seen by every cell; all low when nothing fires
	typedef struct packed {
		logic append;
		logic take;
		logic remove;
	} cell_ctrl_t;

endpackage

// ----- design/fqr_cell.sv -----
// One slot of the queue row: a valid flag and an identifier.
// Shifts in from the next cell on take, or on remove from the first matching cell onward; loads on append.
// Depends on fqr_pkg for the control bundle.
module fqr_cell #(
	parameter int unsigned ID_BITS = fqr_pkg::ID_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fqr_pkg::cell_ctrl_t     ctrl,
	input  logic [ID_BITS-1:0]      req_id,
	input  logic                    prev_valid,
	input  logic                    next_valid,
	input  logic [ID_BITS-1:0]      next_id,
	input  logic                    hit_in,
	output logic                    hit_out,
	output logic                    valid,
	output logic [ID_BITS-1:0]      id,
	output logic                    nxt_valid,
	output logic [ID_BITS-1:0]      nxt_id
);

	logic               valid_q;
	logic [ID_BITS-1:0] id_q;
	logic               match;
	logic               shift;
	logic               load;

	assign match   = valid_q && (id_q == req_id);
	assign hit_out = hit_in | match;

	// Every cell from the first match onward pulls its neighbor in
	assign shift = ctrl.take | (ctrl.remove & (hit_in | match));
	// Append lands in the first empty cell
	assign load  = ctrl.append & ~valid_q & prev_valid;

	always_comb begin
		nxt_valid = valid_q;
		nxt_id    = id_q;
		if (shift) begin
			nxt_valid = next_valid;
			nxt_id    = next_id;
		end else if (load) begin
			nxt_valid = 1'b1;
			nxt_id    = req_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		id_q <= nxt_id;
	end

	assign valid = valid_q;
	assign id    = id_q;

endmodule

// ----- design/fifo_queue_with_remove_top.sv -----
// Top level of the ready queue: a row of fqr_cell slots, the occupancy
// count and a registered result stage on the output stream.
// Depends on fqr_pkg and fqr_cell.
//
//  channel | dir | fields (low bit first)
//  s_*     | in  | func[1:0], entry_id[9:2]
//  m_*     | out | ok[0], taken_id[8:1], head_valid[9], head_id[17:10], count[23:18]
//
// One item per cycle: the whole row updates in the cycle the item is
// accepted, and its result sits in the output register the cycle after.
// The remove path is set by the match ripple along the row of cells.
// Reset empties the queue; identifiers in the slots are not cleared.
// A stalled output holds its result and blocks new items until taken.
module fifo_queue_with_remove_top #(
	parameter int unsigned QUEUE_DEPTH = fqr_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned ID_BITS     = fqr_pkg::ID_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [fqr_pkg::IN_DATA_W-1:0]   s_tdata,  // func, entry_id
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [fqr_pkg::OUT_DATA_W-1:0]  m_tdata   // ok, taken_id, head_valid, head_id, count
);

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic                            fire;
	logic [fqr_pkg::FUNC_W-1:0]      func;
	logic [fqr_pkg::PORT_ID_W-1:0]   entry_id;
	logic [fqr_pkg::WIDE_ID_W-1:0]   entry_wide;
	logic [ID_BITS-1:0]              req_id;
	fqr_pkg::cell_ctrl_t             ctrl;

	logic [QUEUE_DEPTH-1:0]          cell_valid;
	logic [QUEUE_DEPTH-1:0]          cell_hit;
	logic [QUEUE_DEPTH-1:0]          cell_nxt_valid;
	logic [ID_BITS-1:0]              cell_id     [QUEUE_DEPTH];
	logic [ID_BITS-1:0]              cell_nxt_id [QUEUE_DEPTH];

	logic [CNT_W-1:0]                count_q;
	logic [CNT_W-1:0]                count_d;
	logic                            ok;
	logic [ID_BITS-1:0]              taken;
	logic [fqr_pkg::WIDE_ID_W-1:0]   taken_wide;
	logic [fqr_pkg::WIDE_ID_W-1:0]   head_wide;

	logic                            out_valid_q;
	logic                            ok_q;
	logic [fqr_pkg::PORT_ID_W-1:0]   taken_q;
	logic                            head_valid_q;
	logic [fqr_pkg::PORT_ID_W-1:0]   head_id_q;
	logic [fqr_pkg::COUNT_W-1:0]     count_out_q;

	assign s_tready = ~out_valid_q | m_tready;
	assign fire     = s_tvalid & s_tready;

	assign func       = s_tdata[fqr_pkg::FUNC_W-1:0];
	assign entry_id   = s_tdata[fqr_pkg::FUNC_W +: fqr_pkg::PORT_ID_W];
	assign entry_wide = fqr_pkg::WIDE_ID_W'(entry_id);
	assign req_id     = entry_wide[ID_BITS-1:0];

	always_comb begin
		ctrl = '0;
		if (fire) begin
			case (func)
				fqr_pkg::OP_APPEND: ctrl.append = 1'b1;
				fqr_pkg::OP_TAKE:   ctrl.take   = 1'b1;
				fqr_pkg::OP_REMOVE: ctrl.remove = 1'b1;
				default:            ctrl        = '0;
			endcase
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic               prev_valid;
		logic               next_valid;
		logic [ID_BITS-1:0] next_id;
		logic               hit_in;

		if (i == 0) begin : g_first
			assign prev_valid = 1'b1;
			assign hit_in     = 1'b0;
		end else begin : g_mid
			assign prev_valid = cell_valid[i-1];
			assign hit_in     = cell_hit[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign next_valid = 1'b0;
			assign next_id    = '0;
		end else begin : g_inner
			assign next_valid = cell_valid[i+1];
			assign next_id    = cell_id[i+1];
		end

		fqr_cell #(
			.ID_BITS(ID_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.req_id    (req_id),
			.prev_valid(prev_valid),
			.next_valid(next_valid),
			.next_id   (next_id),
			.hit_in    (hit_in),
			.hit_out   (cell_hit[i]),
			.valid     (cell_valid[i]),
			.id        (cell_id[i]),
			.nxt_valid (cell_nxt_valid[i]),
			.nxt_id    (cell_nxt_id[i])
		);
	end

	always_comb begin
		ok      = 1'b0;
		taken   = '0;
		count_d = count_q;
		if (ctrl.append && !cell_valid[QUEUE_DEPTH-1]) begin
			ok      = 1'b1;
			count_d = count_q + CNT_W'(1);
		end else if (ctrl.take && cell_valid[0]) begin
			ok      = 1'b1;
			taken   = cell_id[0];
			count_d = count_q - CNT_W'(1);
		end else if (ctrl.remove && cell_hit[QUEUE_DEPTH-1]) begin
			ok      = 1'b1;
			taken   = req_id;
			count_d = count_q - CNT_W'(1);
		end
	end

	assign taken_wide = fqr_pkg::WIDE_ID_W'(taken);
	// Empty head reads as zero
	assign head_wide  = cell_nxt_valid[0] ? fqr_pkg::WIDE_ID_W'(cell_nxt_id[0]) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ok_q         <= ok;
			taken_q      <= taken_wide[fqr_pkg::PORT_ID_W-1:0];
			head_valid_q <= cell_nxt_valid[0];
			head_id_q    <= head_wide[fqr_pkg::PORT_ID_W-1:0];
			count_out_q  <= fqr_pkg::COUNT_W'(count_d);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {count_out_q, head_id_q, head_valid_q, taken_q, ok_q};

endmodule
